@@ design/slgu_pkg.sv @@
// ----------------------------------------------------------------------------
// slgu_pkg
// Shared types and constants of the shuffled minimal standard generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slgu_pkg;

    localparam int unsigned VALUE_W = 31;   // generator word width
    localparam int unsigned MULT_W  = 15;   // width of the multiplier constant
    localparam int unsigned PROD_W  = VALUE_W + MULT_W;

    typedef logic [VALUE_W-1:0] t_value;

    localparam logic [MULT_W-1:0] MULT    = 15'd16807;
    localparam t_value            MODULUS = 31'h7FFF_FFFF;   // 2^31 - 1
    localparam t_value            SEED_DEFAULT = 31'd1;

endpackage

`default_nettype wire

@@ design/slgu_lcg.sv @@
// ----------------------------------------------------------------------------
// slgu_lcg
// One step x * 16807 mod (2^31 - 1): registered product, Mersenne fold.
// ----------------------------------------------------------------------------
`default_nettype none

module slgu_lcg (
    input  wire                  i_clk,
    input  wire slgu_pkg::t_value i_x,   // sampled every cycle
    output slgu_pkg::t_value      o_y    // step of i_x from previous cycle
);

    logic [slgu_pkg::PROD_W-1:0]  r_prod;
    logic [slgu_pkg::VALUE_W:0]   w_sum;
    logic [slgu_pkg::VALUE_W:0]   w_mod;

    always_ff @(posedge i_clk) begin
        r_prod <= slgu_pkg::PROD_W'(i_x) * slgu_pkg::PROD_W'(slgu_pkg::MULT);
    end

    // 2^31 == 1 mod M: fold the high part onto the low part, one subtract.
    always_comb begin
        w_mod = {1'b0, slgu_pkg::MODULUS};
        w_sum = {1'b0, r_prod[slgu_pkg::VALUE_W-1:0]}
              + (slgu_pkg::VALUE_W + 1)'(r_prod[slgu_pkg::PROD_W-1:slgu_pkg::VALUE_W]);
        if (w_sum >= w_mod) begin
            o_y = slgu_pkg::VALUE_W'(w_sum - w_mod);
        end else begin
            o_y = w_sum[slgu_pkg::VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ design/slgu_slot.sv @@
// ----------------------------------------------------------------------------
// slgu_slot
// Shuffle slot index: value / (1 + (2^31-2)/depth), reciprocal multiply with
// one correction step, saturated to depth-1. Estimate, then q*d, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slgu_slot #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire                          i_clk,
    input  wire slgu_pkg::t_value        i_v,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_slot
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int QW = AW + 2;
    localparam int VW = slgu_pkg::VALUE_W;
    localparam logic [63:0] DIV64 = 64'd1 + (64'd2147483646 / 64'(TABLE_DEPTH));
    localparam logic [63:0] RCP64 = (64'd1 << VW) / DIV64;
    localparam logic [VW-1:0] DIV = DIV64[VW-1:0];
    localparam logic [QW-1:0] RCP = RCP64[QW-1:0];

    logic [VW+QW-1:0] w_prod;
    logic [VW+QW-1:0] w_qd;
    logic [QW-1:0]    r_q0;
    logic [QW-1:0]    r_q1;
    logic [VW-1:0]    r_v1;
    logic [VW-1:0]    r_v2;
    logic [VW-1:0]    r_qd;
    logic [VW-1:0]    w_rem;
    logic [QW-1:0]    w_q;

    assign w_prod = (VW + QW)'(i_v) * (VW + QW)'(RCP);
    assign w_qd   = (VW + QW)'(r_q0) * (VW + QW)'(DIV);

    // estimate is the quotient or one below it
    always_ff @(posedge i_clk) begin
        r_q0 <= w_prod[VW+QW-1:VW];
        r_v1 <= i_v;
        r_q1 <= r_q0;
        r_v2 <= r_v1;
        r_qd <= w_qd[VW-1:0];
    end

    always_comb begin
        w_rem = r_v2 - r_qd;
        w_q   = r_q1 + QW'(w_rem >= DIV);
        if (w_q >= QW'(TABLE_DEPTH)) begin
            o_slot = AW'(TABLE_DEPTH - 1);
        end else begin
            o_slot = w_q[AW-1:0];
        end
    end

endmodule

`default_nettype wire

@@ design/shuffled_lcg_uniform_generator_unit.sv @@
// ----------------------------------------------------------------------------
// shuffled_lcg_uniform_generator_unit
// Minimal standard generator (16807, 2^31-1) behind a Bays-Durham shuffle.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one word per draw request; bit 0 of tdata = restart.
//   m_axis: one word per request; tdata[30:0] = deviate in 1..2^31-2,
//           divide by 2^31-1 for a fraction.
//   cfg:    i_cfg_data is the seed, taken on i_cfg_valid (ready is
//           always high). Write it only while no request is in flight.
// Sequence:
//   A plain draw runs through accept, slot divider and generator step,
//   table read and write-back; the result is registered at write-back.
//   A restart, or the first draw after reset, first loads the seed, then
//   walks TABLE_DEPTH+8 generator steps, each waiting on the step unit's
//   product register, and then runs as a plain draw.
// Reset: seed returns to 1 and the unit is unseeded; the table is not
//   cleared, the first draw refills it before any read.
// Stall: a finished word waits in the output register; a new request may be
//   accepted meanwhile and its write-back holds until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_lcg_uniform_generator_unit #(
    parameter int TABLE_DEPTH = 32   // 8..64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero fill
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] value, [31] zero fill
    // seed register
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [30:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int JW = $clog2(TABLE_DEPTH + 8);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_FILL_A = 3'd2;
    localparam logic [2:0] ST_FILL_B = 3'd3;
    localparam logic [2:0] ST_SLOT0  = 3'd4;
    localparam logic [2:0] ST_SLOT1  = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;
    localparam logic [2:0] ST_WRITE  = 3'd7;

    logic [2:0]        r_state, n_state;
    slgu_pkg::t_value  r_seed;
    slgu_pkg::t_value  r_gen, n_gen;      // generator value
    slgu_pkg::t_value  r_last, n_last;    // last output, 0 = unseeded
    logic [JW-1:0]     r_j, n_j;          // warm-up countdown
    logic [AW-1:0]     r_slot, n_slot;
    logic              r_out_valid, n_out_valid;
    slgu_pkg::t_value  r_out_data, n_out_data;

    // shuffle table, one write and one registered read port
    slgu_pkg::t_value  r_mem [TABLE_DEPTH];
    slgu_pkg::t_value  r_rd;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    slgu_pkg::t_value  w_mem_wdata;
    logic              w_mem_re;

    slgu_pkg::t_value  w_step;
    logic [AW-1:0]     w_slot;
    logic              w_in_acc;
    logic              w_out_free;

    slgu_lcg u_lcg (
        .i_clk (i_clk),
        .i_x   (r_gen),
        .o_y   (w_step)
    );

    slgu_slot #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slot (
        .i_clk  (i_clk),
        .i_v    (r_last),
        .o_slot (w_slot)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data};
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_last      = r_last;
        n_j         = r_j;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_slot;
        w_mem_wdata = r_gen;
        w_mem_re    = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    // unseeded draw behaves as a restart
                    if (s_axis_tdata[0] || (r_last == '0)) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_SLOT0;
                    end
                end
            end
            ST_LOAD: begin
                // zero or modulus would lock the generator
                if ((r_seed == '0) || (r_seed == slgu_pkg::MODULUS)) begin
                    n_gen = slgu_pkg::SEED_DEFAULT;
                end else begin
                    n_gen = r_seed;
                end
                n_j     = JW'(TABLE_DEPTH + 7);
                n_state = ST_FILL_A;
            end
            ST_FILL_A: begin
                n_state = ST_FILL_B;
            end
            ST_FILL_B: begin
                n_gen       = w_step;
                w_mem_wdata = w_step;
                w_mem_waddr = r_j[AW-1:0];
                w_mem_we    = (r_j < JW'(TABLE_DEPTH));
                if (r_j == '0) begin
                    // table[0] holds the final step
                    n_last  = w_step;
                    n_state = ST_SLOT0;
                end else begin
                    n_j     = r_j - JW'(1);
                    n_state = ST_FILL_A;
                end
            end
            ST_SLOT0: begin
                n_state = ST_SLOT1;
            end
            ST_SLOT1: begin
                n_gen   = w_step;
                n_state = ST_READ;
            end
            ST_READ: begin
                w_mem_re = 1'b1;
                n_slot   = w_slot;
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    w_mem_we    = 1'b1;
                    n_last      = r_rd;
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= slgu_pkg::SEED_DEFAULT;
            r_gen       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_slot     <= n_slot;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd <= r_mem[w_slot];
        end
    end

`ifndef NO_ASSERTIONS
    // a new word appears only from the write-back step
    a_out_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || m_axis_tready) ##1 r_out_valid |-> $past(r_state) == ST_WRITE)
        else $error("result word not produced by write-back");

    // the table is never touched between requests
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_mem_we)
        else $error("table written while idle");

    // a draw only runs on a seeded generator
    a_seeded_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_last != '0) && (r_gen != '0))
        else $error("draw on unseeded generator");

    // a stalled word is not overwritten
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_data))
        else $error("pending result word lost");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shuffled minimal standard generator. Draw
// requests and seed writes go in through the stream and config ports. A
// local predictor of the generator and its shuffle table computes each
// expected deviate, and every result word is compared against it in order.
// ----------------------------------------------------------------------------

module testbench;

    localparam int TABLE_DEPTH  = 32;
    localparam int WARMUP_STEPS = TABLE_DEPTH + 8;
    // slot = previous deviate / (1 + (m - 1) / depth)
    localparam int unsigned SLOT_DIV = 1 + (int'(slgu_pkg::MODULUS) - 1) / TABLE_DEPTH;

    localparam int RANDOM_ITEMS  = 700;
    localparam int QUIET_ITEMS   = 100;     // tail of the run with no idling
    localparam int SETTLE_CYCLES = 8;       // wait after the drain before a seed write
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic             wr_seed;    // write the seed register before this request
        slgu_pkg::t_value seed;
        logic             restart;
    } t_req_step;

    localparam int N_DIRECTED = 18;

    // Expected words all come from the predictor: no deviate here can be
    // read off by hand.
    localparam t_req_step DIRECTED_STEPS [N_DIRECTED] = '{
        '{1'b0, 31'd0,           1'b0},  // unseeded draw, default seed
        '{1'b0, 31'd0,           1'b0},
        '{1'b0, 31'd0,           1'b1},  // restart from the default seed
        '{1'b1, 31'd0,           1'b1},  // zero seed behaves as one
        '{1'b0, 31'd0,           1'b0},
        '{1'b1, 31'h7FFF_FFFF,   1'b0},  // seed write alone changes nothing
        '{1'b0, 31'd0,           1'b0},
        '{1'b0, 31'd0,           1'b1},  // seed equal to modulus behaves as one
        '{1'b1, 31'h7FFF_FFFE,   1'b1},  // largest legal seed
        '{1'b0, 31'd0,           1'b0},
        '{1'b1, 31'h5555_5555,   1'b1},
        '{1'b0, 31'd0,           1'b0},
        '{1'b1, 31'h2AAA_AAAA,   1'b1},
        '{1'b0, 31'd0,           1'b0},
        '{1'b1, 31'd1,           1'b1},
        '{1'b0, 31'd0,           1'b1},  // back-to-back restarts
        '{1'b1, 31'd12345,       1'b1},
        '{1'b0, 31'd0,           1'b0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [0] restart, [7:1] zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;      // [30:0] value, [31] zero fill
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data;

    // predictor state
    slgu_pkg::t_value seed_reg;
    slgu_pkg::t_value shuffle_tbl [TABLE_DEPTH];
    slgu_pkg::t_value last_deviate;
    slgu_pkg::t_value gen_state;
    slgu_pkg::t_value expected_values [$];

    int  src_idle_pct;
    int  snk_idle_pct;
    bit  quiet;
    int  n_draws;
    int  n_refill_draws;
    int  n_seed_writes;
    int  n_checked;
    int  n_errors;
    int  cycle_count;

    shuffled_lcg_uniform_generator_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // x * 16807 mod (2^31 - 1)
    function automatic slgu_pkg::t_value lcg_step(slgu_pkg::t_value x);
        longint unsigned prod;
        prod = 64'(x) * 64'(slgu_pkg::MULT);
        return slgu_pkg::t_value'(prod % 64'(slgu_pkg::MODULUS));
    endfunction

    function automatic slgu_pkg::t_value draw_deviate(bit restart);
        int unsigned      slot;
        slgu_pkg::t_value x;
        slgu_pkg::t_value picked;
        if (restart || last_deviate == '0) begin
            x = seed_reg;
            // both would lock the generator
            if (x == '0 || x == slgu_pkg::MODULUS) x = 31'd1;
            for (int j = WARMUP_STEPS - 1; j >= 0; j--) begin
                x = lcg_step(x);
                if (j < TABLE_DEPTH) shuffle_tbl[j] = x;
            end
            gen_state    = x;
            last_deviate = shuffle_tbl[0];
        end
        gen_state = lcg_step(gen_state);
        slot = last_deviate / SLOT_DIV;
        if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
        picked           = shuffle_tbl[slot];
        shuffle_tbl[slot] = gen_state;
        last_deviate     = picked;
        return picked;
    endfunction

    // Prediction on accepted requests and seed writes, checking on result words.
    always @(posedge i_clk) begin
        slgu_pkg::t_value want;
        if (!i_rst_n) begin
            seed_reg     = slgu_pkg::SEED_DEFAULT;
            last_deviate = '0;
            gen_state    = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) seed_reg = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                n_draws++;
                if (s_axis_tdata[0] || last_deviate == '0) n_refill_draws++;
                expected_values = {expected_values, draw_deviate(s_axis_tdata[0])};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_values.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual value %0d",
                             $time, m_axis_tdata[30:0]);
                    n_errors++;
                end else begin
                    want = expected_values.pop_front();
                    n_checked++;
                    if (m_axis_tdata[30:0] !== want) begin
                        $display("%0t: value expected %0d, actual %0d",
                                 $time, want, m_axis_tdata[30:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[31] !== 1'b0) begin
                        $display("%0t: fill bit expected 0, actual %b",
                                 $time, m_axis_tdata[31]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Result side backpressure in bursts.
    initial begin : result_sink
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 99) < snk_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("shuffled_lcg_uniform_generator_unit: mismatch");
        $finish;
    end

    // Holds valid until the word is taken; valid only drops for a gap.
    task automatic send_request(bit restart);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 19);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Seed is only written with the unit drained.
    task automatic write_seed(slgu_pkg::t_value v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        n_seed_writes++;
    endtask

    function automatic slgu_pkg::t_value pick_seed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return slgu_pkg::MODULUS;
            2:       return slgu_pkg::MODULUS - 31'd1;
            3:       return 31'd1;
            default: return slgu_pkg::t_value'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        bit do_restart;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        quiet          = 1'b0;
        src_idle_pct   = 25;
        snk_idle_pct   = 25;
        n_draws        = 0;
        n_refill_draws = 0;
        n_seed_writes  = 0;
        n_checked      = 0;
        n_errors       = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_STEPS[k]) begin
            if (DIRECTED_STEPS[k].wr_seed) write_seed(DIRECTED_STEPS[k].seed);
            send_request(DIRECTED_STEPS[k].restart);
        end

        // Mostly plain draws on a warm table; occasional reseeds, some
        // without a restart, and stray restarts.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                src_idle_pct = $urandom_range(0, 2) * 20;
                snk_idle_pct = $urandom_range(0, 2) * 20;
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            do_restart = ($urandom_range(0, 24) == 0);
            if ($urandom_range(0, 59) == 0) begin
                write_seed(pick_seed());
                do_restart = ($urandom_range(0, 3) != 0);
            end
            send_request(do_restart);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d draws (%0d refilled the table), %0d seed writes",
                 n_draws, n_refill_draws, n_seed_writes);
        $display("run: %0d deviates compared, %0d errors", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("shuffled_lcg_uniform_generator_unit: match");
        end else begin
            $display("shuffled_lcg_uniform_generator_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/slgu_pkg.sv
design/slgu_lcg.sv
design/slgu_slot.sv
design/shuffled_lcg_uniform_generator_unit.sv
tb/testbench.sv
